// File: rtl/core/cpbs_pkg.sv
// cpbs_pkg: shared types and constants for the complex power-by-squaring block.
// Used by cpbs_ctrl, cpbs_dp and complex_power_by_squaring. No dependencies.
package cpbs_pkg;

  localparam int DATA_W = 32;               // Q-format component width
  localparam int PROD_W = 2 * DATA_W;       // full product width
  localparam int SUM_W  = PROD_W + 2;       // sum/difference of two products, with margin

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,     // skip leading zero exponent bits
    ST_SQ_MUL,   // acc * acc partial products
    ST_SQ_SUM,   // combine, shift, saturate
    ST_BM_MUL,   // base * acc partial products
    ST_BM_SUM,
    ST_FINISH    // wait for the output register
  } state_e;

  typedef struct packed {
    logic load;       // capture input word, acc = 1.0
    logic shift;      // advance to next exponent bit
    logic take_base;  // acc = base
    logic mul_base;   // multiplier x operand is base instead of acc
    logic mul_go;     // register the four partial products
    logic sum_go;     // update acc from registered products
    logic load_out;   // copy acc and overflow to the output register
  } cmd_t;

  typedef struct packed {
    logic msb;        // current exponent bit
  } status_t;

endpackage

// File: rtl/core/cpbs_dp.sv
// cpbs_dp: datapath with base/acc registers, exponent shifter and one complex multiplier.
// Driven by cpbs_ctrl through cpbs_pkg::cmd_t; depends on cpbs_pkg.
module cpbs_dp import cpbs_pkg::*; #(
  parameter int EXP_BITS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  cmd_t                     cmd_i,
  output status_t                  stat_o,
  input  logic signed [DATA_W-1:0] base_real_i,
  input  logic signed [DATA_W-1:0] base_imag_i,
  input  logic        [DATA_W-1:0] exponent_i,
  output logic signed [DATA_W-1:0] power_real_o,
  output logic signed [DATA_W-1:0] power_imag_o,
  output logic                     overflow_o
);

  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  // returns {saturated, value}
  function automatic logic [DATA_W:0] sat (input logic signed [SUM_W-1:0] v);
    logic [SUM_W-DATA_W:0] top;
    top = v[SUM_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      return {1'b0, v[DATA_W-1:0]};
    end else if (v[SUM_W-1]) begin
      return {1'b1, SAT_MIN};
    end else begin
      return {1'b1, SAT_MAX};
    end
  endfunction

  logic signed [DATA_W-1:0] base_re_q, base_im_q;
  logic signed [DATA_W-1:0] acc_re_q, acc_im_q;
  logic        [EXP_BITS-1:0] exp_q;
  logic                     ovf_q;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;

  logic signed [DATA_W-1:0] x_re, x_im;
  logic signed [PROD_W-1:0] m_rr, m_ii, m_ri, m_ir;
  logic signed [SUM_W-1:0]  s_re, s_im, sh_re, sh_im;
  logic        [DATA_W:0]   sat_re, sat_im;

  assign x_re = cmd_i.mul_base ? base_re_q : acc_re_q;
  assign x_im = cmd_i.mul_base ? base_im_q : acc_im_q;

  assign m_rr = x_re * acc_re_q;
  assign m_ii = x_im * acc_im_q;
  assign m_ri = x_re * acc_im_q;
  assign m_ir = x_im * acc_re_q;

  assign s_re  = SUM_W'(p_rr_q) - SUM_W'(p_ii_q);
  assign s_im  = SUM_W'(p_ri_q) + SUM_W'(p_ir_q);
  assign sh_re = s_re >>> FRAC_BITS;
  assign sh_im = s_im >>> FRAC_BITS;
  assign sat_re = sat(sh_re);
  assign sat_im = sat(sh_im);

  assign stat_o.msb = exp_q[EXP_BITS-1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_re_q <= base_real_i;
      base_im_q <= base_imag_i;
      exp_q     <= EXP_BITS'(exponent_i);
      acc_re_q  <= ONE;
      acc_im_q  <= '0;
      ovf_q     <= 1'b0;
    end else begin
      if (cmd_i.shift) begin
        exp_q <= exp_q << 1;
      end
      if (cmd_i.take_base) begin
        acc_re_q <= base_re_q;
        acc_im_q <= base_im_q;
      end else if (cmd_i.sum_go) begin
        acc_re_q <= sat_re[DATA_W-1:0];
        acc_im_q <= sat_im[DATA_W-1:0];
        ovf_q    <= ovf_q | sat_re[DATA_W] | sat_im[DATA_W];
      end
    end
    if (cmd_i.mul_go) begin
      p_rr_q <= m_rr;
      p_ii_q <= m_ii;
      p_ri_q <= m_ri;
      p_ir_q <= m_ir;
    end
    if (cmd_i.load_out) begin
      power_real_o <= acc_re_q;
      power_imag_o <= acc_im_q;
      overflow_o   <= ovf_q;
    end
  end

endmodule

// File: rtl/core/cpbs_ctrl.sv
// cpbs_ctrl: sequencer for square-and-multiply, bit counter and both handshakes.
// Commands cpbs_dp through cpbs_pkg::cmd_t; depends on cpbs_pkg.
module cpbs_ctrl import cpbs_pkg::*; #(
  parameter int EXP_BITS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t stat_i,
  output cmd_t    cmd_o
);

  localparam int CNT_W = $clog2(EXP_BITS + 1);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              cnt_last;
  logic              out_free;

  assign cnt_last    = (cnt_q == CNT_W'(1));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CNT_W'(EXP_BITS);
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.shift = 1'b1;
        cnt_d       = cnt_q - CNT_W'(1);
        if (stat_i.msb) begin
          cmd_o.take_base = 1'b1;
          state_d = cnt_last ? ST_FINISH : ST_SQ_MUL;
        end else if (cnt_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_SQ_MUL: begin
        cmd_o.mul_go = 1'b1;
        state_d      = ST_SQ_SUM;
      end
      ST_SQ_SUM: begin
        cmd_o.sum_go = 1'b1;
        if (stat_i.msb) begin
          state_d = ST_BM_MUL;
        end else begin
          cmd_o.shift = 1'b1;
          cnt_d       = cnt_q - CNT_W'(1);
          state_d     = cnt_last ? ST_FINISH : ST_SQ_MUL;
        end
      end
      ST_BM_MUL: begin
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_base = 1'b1;
        state_d        = ST_BM_SUM;
      end
      ST_BM_SUM: begin
        cmd_o.sum_go = 1'b1;
        cmd_o.shift  = 1'b1;
        cnt_d        = cnt_q - CNT_W'(1);
        state_d      = cnt_last ? ST_FINISH : ST_SQ_MUL;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // the output register is only overwritten once its word has left
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("output word overwritten while stalled");

  // bit counter never runs out while bits are still being processed
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_SQ_MUL || state_q == ST_SQ_SUM ||
     state_q == ST_BM_MUL || state_q == ST_BM_SUM) |-> (cnt_q != '0))
    else $error("exponent bit counter underflow");

  // an accepted word always starts with a scan of the full exponent
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SCAN &&
                                     cnt_q == CNT_W'(EXP_BITS)))
    else $error("item did not start scanning");

  // multiplier results are consumed in the very next cycle
  a_mul_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_go |=> cmd_o.sum_go)
    else $error("partial products not combined");

endmodule

// File: rtl/core/complex_power_by_squaring.sv
// complex_power_by_squaring: top level, base^exponent in signed fixed point.
// Instantiates cpbs_ctrl and cpbs_dp; depends on cpbs_pkg.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+----------------------------------------
//  in      | input     | in_valid_i / in_stall_o | base_real_i, base_imag_i, exponent_i
//  out     | output    | out_valid_o/out_stall_i | power_real_o, power_imag_o, overflow_o
//
// One word at a time. Leading zero exponent bits are skipped in ST_SCAN, which also turns
// the first set bit into acc = base; every later bit is squared on the shared complex
// multiplier (then add/shift/saturate) and, when it is set, multiplied by the base the
// same way; ST_FINISH then loads the result into the output register.
// A finished word waits in the output register under out_stall_i while the next input
// word is taken; asynchronous active-low reset clears the control state only.
module complex_power_by_squaring import cpbs_pkg::*; #(
  parameter int EXP_BITS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] base_real_i,
  input  logic signed [DATA_W-1:0] base_imag_i,
  input  logic        [DATA_W-1:0] exponent_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] power_real_o,
  output logic signed [DATA_W-1:0] power_imag_o,
  output logic                     overflow_o
);

  cmd_t    cmd;
  status_t stat;

  cpbs_ctrl #(
    .EXP_BITS (EXP_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cpbs_dp #(
    .EXP_BITS  (EXP_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .base_real_i  (base_real_i),
    .base_imag_i  (base_imag_i),
    .exponent_i   (exponent_i),
    .power_real_o (power_real_o),
    .power_imag_o (power_imag_o),
    .overflow_o   (overflow_o)
  );

endmodule
